>>> hw/rtl/armc_pkg.sv
// shared types and codes for the address range merge cache
package armc_pkg;

   localparam int ADDR_W  = 48;
   localparam int LEN_W   = 40;
   localparam int TAG_W   = 32;
   localparam int CNT_W   = 7;
   localparam int STAT_W  = 3;
   localparam int SHIFT_W = 5;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INVAL  = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;
   localparam logic [1:0] CMD_RSVD   = 2'd3;

   localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
   localparam logic [STAT_W-1:0] ST_CREATED  = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
   localparam logic [STAT_W-1:0] ST_FLUSHED  = 3'd5;

   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;
   localparam logic [TAG_W-1:0]   TAG_RESET        = 32'd1;
   localparam int                 MERGED_MAX       = 127;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic [TAG_W-1:0]  tag;
      logic [CNT_W-1:0]  merged;
   } result_type;

endpackage

>>> hw/rtl/address_range_merge_cache_top.sv
// top level of the address range merge cache
// One request at a time. After reset the table is cleared, during
// which req_stall is high. A lookup takes (2 + G) scans of the table,
// where G >= 1 is the number of grow scans until the merged range stops
// widening; a hit ends after the first scan. Invalidate takes one scan;
// flush clears every entry. Each scan reads one table entry per cycle
// from the single read port of the table memory. The result sits in an
// output register, so the next request is taken once the engine has
// handed it over.
module address_range_merge_cache_top import armc_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [ADDR_W-1:0]  req_range_start,
   input  logic [LEN_W-1:0]   req_range_length,
   input  logic [TAG_W-1:0]   req_invalid_tag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [ADDR_W-1:0]  rsp_region_start,
   output logic [ADDR_W-1:0]  rsp_region_length,
   output logic [TAG_W-1:0]   rsp_region_tag,
   output logic [CNT_W-1:0]   rsp_merged_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SHIFT_W-1:0] csr_page_shift
);

   localparam int AW = $clog2(ENTRIES);

   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;
   logic               busy, res_valid, res_ready;
   result_type         res;
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   entry_type          wr_data, rd_data;

   assign csr_ready = 1'b1;
   assign shift_in  = (csr_valid && csr_ready) ? csr_page_shift : shift_ff;
   assign req_stall = busy;
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= PAGE_SHIFT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   armc_engine #(.ENTRIES(ENTRIES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .page_shift(shift_ff),
      .go        (req_valid && !req_stall),
      .cmd       (req_command),
      .rstart    (req_range_start),
      .rlength   (req_range_length),
      .itag      (req_invalid_tag),
      .busy      (busy),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   armc_table #(.ENTRIES(ENTRIES)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_region_start  = rsp_ff.start;
   assign rsp_region_length = rsp_ff.length;
   assign rsp_region_tag    = rsp_ff.tag;
   assign rsp_merged_count  = rsp_ff.merged;

endmodule

>>> hw/rtl/armc_table.sv
// region table memory, one write and one registered read port
module armc_table import armc_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  entry_type                  wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output entry_type                  rd_data
);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/armc_engine.sv
// scan and merge sequencer over the region table
module armc_engine import armc_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [SHIFT_W-1:0]         page_shift,
   input  logic                       go,
   input  logic [1:0]                 cmd,
   input  logic [ADDR_W-1:0]          rstart,
   input  logic [LEN_W-1:0]           rlength,
   input  logic [TAG_W-1:0]           itag,
   output logic                       busy,
   output logic                       res_valid,
   input  logic                       res_ready,
   output result_type                 res,
   output logic                       wr_en,
   output logic [$clog2(ENTRIES)-1:0] wr_addr,
   output entry_type                  wr_data,
   output logic                       rd_en,
   output logic [$clog2(ENTRIES)-1:0] rd_addr,
   input  entry_type                  rd_data
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int RW = ADDR_W + 3;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LEFT   = 4'd2;
   localparam logic [3:0] S_GROW   = 4'd3;
   localparam logic [3:0] S_COMMIT = 4'd4;
   localparam logic [3:0] S_INSERT = 4'd5;
   localparam logic [3:0] S_INVAL  = 4'd6;
   localparam logic [3:0] S_OUT    = 4'd7;

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              pv_ff, pv_in;
   logic [AW-1:0]     pidx_ff, pidx_in;
   logic [ADDR_W-1:0] s_ff, s_in;
   logic [LEN_W-1:0]  l_ff, l_in;
   logic [TAG_W-1:0]  itag_ff, itag_in;
   logic              lf_ff, lf_in;
   logic [AW-1:0]     lidx_ff, lidx_in;
   logic [ADDR_W-1:0] lstart_ff, lstart_in;
   logic [ADDR_W-1:0] llen_ff, llen_in;
   logic [TAG_W-1:0]  ltag_ff, ltag_in;
   logic              labs_ff, labs_in;
   logic [ADDR_W-1:0] ns_ff, ns_in;
   logic [ADDR_W:0]   ne_ff, ne_in;
   logic              chg_ff, chg_in;
   logic [CW-1:0]     mcnt_ff, mcnt_in;
   logic              ff_ff, ff_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [TAG_W-1:0]  ntag_ff, ntag_in;
   logic              flush_ff, flush_in;
   result_type        res_ff, res_in;

   logic              scan_more, done;
   logic [ADDR_W:0]   d_end, lend, rend;
   logic              right_hit, absorbed;
   logic [RW-1:0]     pgm1, mask, ns_r, ne_r, len_r;
   logic [ADDR_W-1:0] len_sat;
   logic [TAG_W-1:0]  tag_inc;

   assign scan_more = cnt_ff < CW'(ENTRIES);
   assign done      = !scan_more && !pv_ff;
   assign d_end     = {1'b0, rd_data.start} + {1'b0, rd_data.length};
   assign lend      = {1'b0, lstart_ff} + {1'b0, llen_ff};
   assign rend      = {1'b0, s_ff} + (ADDR_W + 1)'(l_ff);
   assign right_hit = rd_data.valid && (rd_data.start > s_ff) && ({1'b0, rd_data.start} <= ne_ff);
   assign absorbed  = right_hit || (rd_data.valid && labs_ff && pidx_ff == lidx_ff);

   assign pgm1    = (RW'(1) << page_shift) - RW'(1);
   assign mask    = ~pgm1;
   assign ns_r    = RW'(ns_ff) & mask;
   assign ne_r    = (RW'(ne_ff) + pgm1) & mask;
   assign len_r   = ne_r - ns_r;
   assign len_sat = (len_r[RW-1:ADDR_W] != '0) ? '1 : len_r[ADDR_W-1:0];
   assign tag_inc = (ntag_ff + TAG_W'(1) == '0) ? TAG_W'(1) : ntag_ff + TAG_W'(1);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pv_in     = 1'b0;
      pidx_in   = pidx_ff;
      s_in      = s_ff;
      l_in      = l_ff;
      itag_in   = itag_ff;
      lf_in     = lf_ff;
      lidx_in   = lidx_ff;
      lstart_in = lstart_ff;
      llen_in   = llen_ff;
      ltag_in   = ltag_ff;
      labs_in   = labs_ff;
      ns_in     = ns_ff;
      ne_in     = ne_ff;
      chg_in    = chg_ff;
      mcnt_in   = mcnt_ff;
      ff_in     = ff_ff;
      slot_in   = slot_ff;
      ntag_in   = ntag_ff;
      flush_in  = flush_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = pidx_ff;
      wr_data   = '0;
      rd_en     = 1'b0;
      rd_addr   = cnt_ff[AW-1:0];

      if (state_ff == S_LEFT || state_ff == S_GROW || state_ff == S_COMMIT ||
          state_ff == S_INVAL) begin
         if (scan_more) begin
            rd_en   = 1'b1;
            pv_in   = 1'b1;
            pidx_in = cnt_ff[AW-1:0];
            cnt_in  = cnt_ff + CW'(1);
         end
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[AW-1:0];
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(ENTRIES - 1)) begin
               cnt_in = '0;
               if (flush_ff) begin
                  res_in        = '0;
                  res_in.status = ST_FLUSHED;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (go) begin
               s_in    = rstart;
               l_in    = rlength;
               itag_in = itag;
               cnt_in  = '0;
               lf_in   = 1'b0;
               res_in  = '0;
               case (cmd)
                  CMD_LOOKUP: state_in = S_LEFT;
                  CMD_INVAL:  state_in = S_INVAL;
                  CMD_FLUSH: begin
                     flush_in = 1'b1;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     res_in.status = ST_NOTFOUND;
                     state_in      = S_OUT;
                  end
               endcase
            end
         end
         S_LEFT: begin
            if (pv_ff && rd_data.valid && rd_data.start <= s_ff &&
                (!lf_ff || rd_data.start >= lstart_ff)) begin
               lf_in     = 1'b1;
               lidx_in   = pidx_ff;
               lstart_in = rd_data.start;
               llen_in   = rd_data.length;
               ltag_in   = rd_data.tag;
            end
            if (done) begin
               cnt_in = '0;
               if (lf_ff && lend >= rend) begin
                  res_in.status = ST_HIT;
                  res_in.start  = lstart_ff;
                  res_in.length = llen_ff;
                  res_in.tag    = ltag_ff;
                  state_in      = S_OUT;
               end else begin
                  labs_in  = lf_ff && ({1'b0, s_ff} <= lend);
                  ns_in    = (lf_ff && ({1'b0, s_ff} <= lend)) ? lstart_ff : s_ff;
                  ne_in    = rend;
                  chg_in   = 1'b0;
                  state_in = S_GROW;
               end
            end
         end
         S_GROW: begin
            if (pv_ff && right_hit && d_end > ne_ff) begin
               ne_in  = d_end;
               chg_in = 1'b1;
            end
            if (done) begin
               cnt_in = '0;
               chg_in = 1'b0;
               if (!chg_ff) begin
                  mcnt_in  = '0;
                  ff_in    = 1'b0;
                  state_in = S_COMMIT;
               end
            end
         end
         S_COMMIT: begin
            if (pv_ff) begin
               if (absorbed) begin
                  wr_en   = 1'b1;
                  mcnt_in = mcnt_ff + CW'(1);
               end
               if ((!rd_data.valid || absorbed) && !ff_ff) begin
                  ff_in   = 1'b1;
                  slot_in = pidx_ff;
               end
            end
            if (done) begin
               cnt_in = '0;
               if (ff_ff) begin
                  state_in = S_INSERT;
               end else begin
                  res_in.status = ST_FULL;
                  state_in      = S_OUT;
               end
            end
         end
         S_INSERT: begin
            wr_en          = 1'b1;
            wr_addr        = slot_ff;
            wr_data.valid  = 1'b1;
            wr_data.start  = ns_r[ADDR_W-1:0];
            wr_data.length = len_sat;
            wr_data.tag    = ntag_ff;
            res_in.status  = ST_CREATED;
            res_in.start   = ns_r[ADDR_W-1:0];
            res_in.length  = len_sat;
            res_in.tag     = ntag_ff;
            res_in.merged  = (mcnt_ff > CW'(MERGED_MAX)) ? CNT_W'(MERGED_MAX) : CNT_W'(mcnt_ff);
            ntag_in        = tag_inc;
            state_in       = S_OUT;
         end
         S_INVAL: begin
            if (pv_ff && rd_data.valid && rd_data.tag == itag_ff &&
                (!lf_ff || rd_data.start < lstart_ff)) begin
               lf_in     = 1'b1;
               lidx_in   = pidx_ff;
               lstart_in = rd_data.start;
            end
            if (done) begin
               cnt_in = '0;
               if (lf_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = lidx_ff;
                  res_in.status = ST_REMOVED;
               end else begin
                  res_in.status = ST_NOTFOUND;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            flush_in = 1'b0;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         pv_ff    <= 1'b0;
         ntag_ff  <= TAG_RESET;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pv_ff    <= pv_in;
         ntag_ff  <= ntag_in;
         flush_ff <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff   <= pidx_in;
      s_ff      <= s_in;
      l_ff      <= l_in;
      itag_ff   <= itag_in;
      lf_ff     <= lf_in;
      lidx_ff   <= lidx_in;
      lstart_ff <= lstart_in;
      llen_ff   <= llen_in;
      ltag_ff   <= ltag_in;
      labs_ff   <= labs_in;
      ns_ff     <= ns_in;
      ne_ff     <= ne_in;
      chg_ff    <= chg_in;
      mcnt_ff   <= mcnt_in;
      ff_ff     <= ff_in;
      slot_ff   <= slot_in;
      res_ff    <= res_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign res_valid = state_ff == S_OUT;
   assign res       = res_ff;

endmodule

>>> hw/rtl/armc_checker.sv
// port-level checks for the address range merge cache
module armc_checker import armc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [STAT_W-1:0]  rsp_status,
   input logic [ADDR_W-1:0]  rsp_region_start,
   input logic [ADDR_W-1:0]  rsp_region_length,
   input logic [TAG_W-1:0]   rsp_region_tag,
   input logic [CNT_W-1:0]   rsp_merged_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_region_tag))
      else $error("response changed while stalled");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken during table clear");

   a_plain_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_REMOVED ||
                    rsp_status == ST_NOTFOUND || rsp_status == ST_FLUSHED)
      |-> rsp_region_start == '0 && rsp_region_length == '0 &&
          rsp_region_tag == '0 && rsp_merged_count == '0)
      else $error("nonzero region fields on status without region");

   a_created_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_CREATED || rsp_status == ST_HIT)
      |-> rsp_region_tag != '0)
      else $error("region reported with tag zero");

   a_hit_no_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_HIT |-> rsp_merged_count == '0)
      else $error("hit reported merged regions");

endmodule

bind address_range_merge_cache_top armc_checker u_armc_checker (.*);
